// ----- sv/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes of the pending transaction tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int ID_W    = 31;
  localparam int TIME_W  = 64;
  localparam int TYPE_W  = 4;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 3;

  // request types
  localparam logic [TYPE_W-1:0] OP_RESERVE  = 4'd0;
  localparam logic [TYPE_W-1:0] OP_MARK     = 4'd1;
  localparam logic [TYPE_W-1:0] OP_COMPLETE = 4'd2;
  localparam logic [TYPE_W-1:0] OP_CANCEL   = 4'd3;
  localparam logic [TYPE_W-1:0] OP_EXPIRE   = 4'd4;
  localparam logic [TYPE_W-1:0] OP_CLEAR    = 4'd5;
  localparam logic [TYPE_W-1:0] OP_QUERY    = 4'd6;
  localparam logic [TYPE_W-1:0] OP_BEGIN    = 4'd7;
  localparam logic [TYPE_W-1:0] OP_END      = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STAT_W-1:0] ST_CONFLICT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_STATE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_BUSY     = 3'd5;

  // transfer kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACKUP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPGRADE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_BEGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKUP_NEXT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPGRADE_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPGRADE_LAST = 3'd4;

  localparam logic [ID_W-1:0] RST_STATUS_ID     = 31'd1;
  localparam logic [ID_W-1:0] RST_BACKUP_BEGIN  = 31'd2;
  localparam logic [ID_W-1:0] RST_BACKUP_NEXT   = 31'd3;
  localparam logic [ID_W-1:0] RST_UPGRADE_FIRST = 31'd4;
  localparam logic [ID_W-1:0] RST_UPGRADE_LAST  = 31'd8;

  typedef struct packed {
    logic [ID_W-1:0] status_msg_id;
    logic [ID_W-1:0] backup_begin_id;
    logic [ID_W-1:0] backup_next_id;
    logic [ID_W-1:0] upgrade_first_id;
    logic [ID_W-1:0] upgrade_last_id;
  } ptt_cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] sent_time;
  } ptt_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ptt_mem_ctl_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic               allowed;
    logic [KIND_W-1:0]  active_kind;
    logic [COUNT_W-1:0] expired_count;
  } ptt_res_t;

endpackage

// ----- sv/ptt_if.sv -----
// ----------------------------------------------------------------------------
// ptt_if
// Request and response channels of the pending transaction tracker.
// ----------------------------------------------------------------------------
interface ptt_req_if;
  logic                         valid;
  logic                         ready;
  logic [ptt_pkg::TYPE_W-1:0]   req_type;
  logic [ptt_pkg::ID_W-1:0]     req_id;
  logic [ptt_pkg::TIME_W-1:0]   time_ms;
  logic [ptt_pkg::TIME_W-1:0]   age_limit;
  logic [ptt_pkg::KIND_W-1:0]   xfer_kind;

  modport source (output valid, req_type, req_id, time_ms, age_limit, xfer_kind,
                  input ready);
  modport sink (input valid, req_type, req_id, time_ms, age_limit, xfer_kind,
                output ready);
endinterface

interface ptt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::STAT_W-1:0]    status;
  logic                          found;
  logic                          allowed;
  logic [ptt_pkg::KIND_W-1:0]    active_kind;
  logic [ptt_pkg::COUNT_W-1:0]   expired_count;

  modport source (output valid, status, found, allowed, active_kind, expired_count,
                  input ready);
  modport sink (input valid, status, found, allowed, active_kind, expired_count,
                output ready);
endinterface

// ----- sv/ptt_mem.sv -----
// ----------------------------------------------------------------------------
// ptt_mem
// Slot memory: id and send time per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module ptt_mem #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  ptt_pkg::ptt_mem_ctl_t ctl,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [IDX_W-1:0]      wr_addr,
  input  ptt_pkg::ptt_entry_t   wr_data,
  output ptt_pkg::ptt_entry_t   rd_data
);

  ptt_pkg::ptt_entry_t mem [TABLE_DEPTH];
  ptt_pkg::ptt_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/ptt_engine.sv -----
// ----------------------------------------------------------------------------
// ptt_engine
// Request sequencer: scans the slot memory, applies the request, and holds
// the response word in an output register.
// ----------------------------------------------------------------------------
module ptt_engine #(
  parameter int TABLE_DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ptt_req_if.sink                in_req,
  ptt_rsp_if.source              out_rsp,
  input  ptt_pkg::ptt_cfg_t      cfg,
  output ptt_pkg::ptt_mem_ctl_t  mem_ctl,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [IDX_W-1:0]       wr_addr,
  output ptt_pkg::ptt_entry_t    wr_data,
  input  ptt_pkg::ptt_entry_t    rd_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ptt_pkg::TYPE_W-1:0]  type_r, type_nxt;
  logic [ptt_pkg::ID_W-1:0]    id_r, id_nxt;
  logic [ptt_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic [ptt_pkg::TIME_W-1:0]  tmo_r, tmo_nxt;
  logic [ptt_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [ptt_pkg::KIND_W-1:0]  active_r, active_nxt;
  logic [TABLE_DEPTH-1:0]      used_r, used_nxt;
  logic [TABLE_DEPTH-1:0]      sent_r, sent_nxt;
  logic [IDX_W-1:0]            rd_idx_r, rd_idx_nxt;
  logic                        cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]            cmp_idx_r, cmp_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic                        free_r, free_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic [ptt_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  ptt_pkg::ptt_res_t           res_r, res_c;
  ptt_pkg::ptt_res_t           out_res_r;
  logic                        out_valid_r;

  logic                        out_free;
  logic                        in_needs_id;
  logic                        scan_need;
  logic                        needs_id;
  logic                        admit;
  logic [ptt_pkg::TIME_W-1:0]  age;
  logic                        cmp_used;
  logic                        cmp_sent;
  logic                        cmp_expire;

  assign out_free = !out_valid_r || out_rsp.ready;

  assign in_needs_id = (in_req.req_type <= ptt_pkg::OP_CANCEL) ||
                       (in_req.req_type == ptt_pkg::OP_QUERY);
  assign scan_need = (in_needs_id && (in_req.req_id != '0)) ||
                     ((in_req.req_type == ptt_pkg::OP_EXPIRE) && (in_req.age_limit != '0));

  assign needs_id = (type_r <= ptt_pkg::OP_CANCEL) || (type_r == ptt_pkg::OP_QUERY);

  always_comb begin
    if (id_r == cfg.status_msg_id) begin
      admit = 1'b1;
    end else if (active_r == ptt_pkg::KIND_BACKUP) begin
      admit = (id_r == cfg.backup_begin_id) || (id_r == cfg.backup_next_id);
    end else if (active_r == ptt_pkg::KIND_UPGRADE) begin
      admit = (id_r >= cfg.upgrade_first_id) && (id_r <= cfg.upgrade_last_id);
    end else begin
      admit = 1'b1;
    end
  end

  // compare stage on the registered memory word
  assign age        = time_r - rd_data.sent_time;
  assign cmp_used   = used_r[cmp_idx_r];
  assign cmp_sent   = sent_r[cmp_idx_r];
  assign cmp_expire = (type_r == ptt_pkg::OP_EXPIRE) && cmp_used && cmp_sent &&
                      (time_r >= rd_data.sent_time) && (age >= tmo_r);

  always_comb begin
    state_nxt    = state_r;
    type_nxt     = type_r;
    id_nxt       = id_r;
    time_nxt     = time_r;
    tmo_nxt      = tmo_r;
    kind_nxt     = kind_r;
    active_nxt   = active_r;
    used_nxt     = used_r;
    sent_nxt     = sent_r;
    rd_idx_nxt   = rd_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    cnt_nxt      = cnt_r;
    mem_ctl      = '0;
    rd_addr      = rd_idx_r;
    wr_addr      = hit_idx_r;
    wr_data.id        = id_r;
    wr_data.sent_time = time_r;
    res_c        = '0;

    if (cmp_vld_r) begin
      if (cmp_used && (rd_data.id == id_r)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = cmp_idx_r;
      end
      if (!cmp_used && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
      if (cmp_expire) begin
        used_nxt[cmp_idx_r] = 1'b0;
        sent_nxt[cmp_idx_r] = 1'b0;
        cnt_nxt             = cnt_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          type_nxt   = in_req.req_type;
          id_nxt     = in_req.req_id;
          time_nxt   = in_req.time_ms;
          tmo_nxt    = in_req.age_limit;
          kind_nxt   = in_req.xfer_kind;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          cnt_nxt    = '0;
          rd_idx_nxt = '0;
          state_nxt  = scan_need ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        rd_idx_nxt    = rd_idx_r + ONE_IDX;
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        res_c.status = ptt_pkg::ST_OK;
        if (needs_id && (id_r == '0)) begin
          res_c.status = ptt_pkg::ST_INVALID;
        end else begin
          unique case (type_r)
            ptt_pkg::OP_RESERVE: begin
              if (hit_r) begin
                res_c.status = ptt_pkg::ST_CONFLICT;
              end else if (!free_r) begin
                res_c.status = ptt_pkg::ST_FULL;
              end else begin
                used_nxt[free_idx_r] = 1'b1;
                sent_nxt[free_idx_r] = 1'b0;
                mem_ctl.wr_en        = 1'b1;
                wr_addr              = free_idx_r;
                wr_data.sent_time    = '0;
              end
            end
            ptt_pkg::OP_MARK: begin
              if (!hit_r || sent_r[hit_idx_r]) begin
                res_c.status = ptt_pkg::ST_STATE;
              end else begin
                sent_nxt[hit_idx_r] = 1'b1;
                mem_ctl.wr_en       = 1'b1;
              end
            end
            ptt_pkg::OP_COMPLETE: begin
              if (!hit_r || !sent_r[hit_idx_r]) begin
                res_c.status = ptt_pkg::ST_STATE;
              end else begin
                used_nxt[hit_idx_r] = 1'b0;
                sent_nxt[hit_idx_r] = 1'b0;
              end
            end
            ptt_pkg::OP_CANCEL: begin
              if (!hit_r) begin
                res_c.status = ptt_pkg::ST_STATE;
              end else begin
                used_nxt[hit_idx_r] = 1'b0;
                sent_nxt[hit_idx_r] = 1'b0;
              end
            end
            ptt_pkg::OP_EXPIRE: begin
              res_c.expired_count = cnt_r;
            end
            ptt_pkg::OP_CLEAR: begin
              used_nxt   = '0;
              sent_nxt   = '0;
              active_nxt = ptt_pkg::KIND_NONE;
            end
            ptt_pkg::OP_QUERY: begin
              res_c.found   = hit_r;
              res_c.allowed = admit;
            end
            ptt_pkg::OP_BEGIN: begin
              if ((kind_r == ptt_pkg::KIND_NONE) || (kind_r == ptt_pkg::KIND_BAD)) begin
                res_c.status = ptt_pkg::ST_INVALID;
              end else if (active_r != ptt_pkg::KIND_NONE) begin
                res_c.status = ptt_pkg::ST_BUSY;
              end else begin
                active_nxt = kind_r;
              end
            end
            ptt_pkg::OP_END: begin
              if ((kind_r == ptt_pkg::KIND_NONE) || (kind_r == ptt_pkg::KIND_BAD)) begin
                res_c.status = ptt_pkg::ST_INVALID;
              end else if (active_r == kind_r) begin
                active_nxt = ptt_pkg::KIND_NONE;
              end
            end
            default: begin
              res_c.status = ptt_pkg::ST_INVALID;
            end
          endcase
        end
        res_c.active_kind = active_nxt;
        state_nxt = out_free ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cmp_vld_nxt = mem_ctl.rd_en;
  assign cmp_idx_nxt = rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ptt_pkg::KIND_NONE;
      used_r      <= '0;
      sent_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      used_r    <= used_nxt;
      sent_r    <= sent_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (((state_r == S_FIN) || (state_r == S_OUT)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    type_r     <= type_nxt;
    id_r       <= id_nxt;
    time_r     <= time_nxt;
    tmo_r      <= tmo_nxt;
    kind_r     <= kind_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    cnt_r      <= cnt_nxt;
    if (state_r == S_FIN) begin
      res_r <= res_c;
    end
    if ((state_r == S_FIN) && out_free) begin
      out_res_r <= res_c;
    end else if ((state_r == S_OUT) && out_free) begin
      out_res_r <= res_r;
    end
  end

  assign in_req.ready          = (state_r == S_IDLE) && rst_n;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_res_r.status;
  assign out_rsp.found         = out_res_r.found;
  assign out_rsp.allowed       = out_res_r.allowed;
  assign out_rsp.active_kind   = out_res_r.active_kind;
  assign out_rsp.expired_count = out_res_r.expired_count;

`ifndef SYNTHESIS
  a_wr_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (state_r == S_FIN))
    else $error("slot memory written outside the finish step");

  a_scan_feeds_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> cmp_vld_r)
    else $error("scan read not followed by compare");

  a_cnt_expire_only: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (type_r != ptt_pkg::OP_EXPIRE)) |-> (cnt_r == '0))
    else $error("expire count set by a non-expire request");

  a_out_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> out_valid_r)
    else $error("waiting on an empty output register");

  a_hit_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && hit_r && (type_r != ptt_pkg::OP_EXPIRE)) |-> used_r[hit_idx_r])
    else $error("lookup hit on a free slot");
`endif

endmodule

// ----- sv/pending_transaction_tracker.sv -----
// ----------------------------------------------------------------------------
// pending_transaction_tracker
// Outstanding request table with send timestamps, timeout expiry and a
// transfer-kind admission filter.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request word (type, id, time, timeout, transfer kind),
//             valid/ready, taken when both are high.
//   out_rsp : one response word per request (status, found, allowed,
//             active kind, expired count), valid/ready.
//   cfg_*   : register write port, one write per cycle at cfg_we.
// Requests that look up the table (reserve, mark sent, complete, cancel and
// query with a nonzero id, expire with a nonzero timeout) read every slot
// of the slot memory through its single read port, one slot per cycle;
// after the last slot a tail step lets the final compare finish, and the
// finish step then applies the request and loads the response register.
// Other requests go straight to the finish step. One request is in flight
// at a time.
// Reset empties the table, ends any transfer and loads the default message
// ids. A stalled response is held in the output register; one more request
// is taken and worked off, then the block waits for the register to drain.
// ----------------------------------------------------------------------------
module pending_transaction_tracker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ptt_req_if.sink                           in_req,
  ptt_rsp_if.source                         out_rsp,
  input  logic                              cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ptt_pkg::ID_W-1:0]          cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  ptt_pkg::ptt_cfg_t     cfg_r;
  ptt_pkg::ptt_mem_ctl_t mem_ctl;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  ptt_pkg::ptt_entry_t   wr_data;
  ptt_pkg::ptt_entry_t   rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.status_msg_id    <= ptt_pkg::RST_STATUS_ID;
      cfg_r.backup_begin_id  <= ptt_pkg::RST_BACKUP_BEGIN;
      cfg_r.backup_next_id   <= ptt_pkg::RST_BACKUP_NEXT;
      cfg_r.upgrade_first_id <= ptt_pkg::RST_UPGRADE_FIRST;
      cfg_r.upgrade_last_id  <= ptt_pkg::RST_UPGRADE_LAST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ptt_pkg::CFG_STATUS_ID:     cfg_r.status_msg_id    <= cfg_wdata;
        ptt_pkg::CFG_BACKUP_BEGIN:  cfg_r.backup_begin_id  <= cfg_wdata;
        ptt_pkg::CFG_BACKUP_NEXT:   cfg_r.backup_next_id   <= cfg_wdata;
        ptt_pkg::CFG_UPGRADE_FIRST: cfg_r.upgrade_first_id <= cfg_wdata;
        ptt_pkg::CFG_UPGRADE_LAST:  cfg_r.upgrade_last_id  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ptt_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  ptt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg     (cfg_r),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule
